// File: src/usart_rsp_pkg.sv
// ============================================================================
// usart_rsp_pkg
// Shared types and constants of the USART receive and status port.
// ============================================================================
package usart_rsp_pkg;

    localparam int DATA_W = 8;
    localparam int FUNC_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_DATA_WR = 3'd0,
        FN_DATA_RD = 3'd1,
        FN_CMD_WR  = 3'd2,
        FN_STAT_RD = 3'd3,
        FN_RX_BYTE = 3'd4,
        FN_TICK    = 3'd5
    } t_func;

    localparam int ST_TXRDY = 0;
    localparam int ST_RXRDY = 1;
    localparam int ST_TXE   = 2;
    localparam int ST_OE    = 4;
    localparam logic [DATA_W-1:0] ST_ERRS_MASK = 8'h38;
    localparam logic [DATA_W-1:0] STATUS_RST   = 8'h05;

    localparam int CMD_TXEN    = 0;
    localparam int CMD_RXEN    = 2;
    localparam int CMD_ERR_RST = 4;
    localparam int CMD_IRST    = 6;
    localparam int CMD_SYNC_SC = 7;

    localparam logic [DATA_W-1:0] RECV_DELAY_RST = 8'd8;
    localparam logic [DATA_W-1:0] HELD_RST       = 8'hff;

    typedef struct packed {
        logic empty;
        logic single;
        logic full;
    } t_fifo_flags;

endpackage

// File: src/usart_receive_status_port.sv
// ============================================================================
// usart_receive_status_port
// Register model of a USART receive path and status port with a receive FIFO.
// ============================================================================
// Each input transfer carries one event: s_axis_tuser selects data write,
// data read, command write, status read, received line byte or timer tick,
// and s_axis_tdata carries the written byte or the received byte.
// Every input transfer yields exactly one output transfer, in order, with
// the read byte in bits 7:0 and the interrupt level after the event in bit 8.
// The receive delay register is written through i_cfg_we / i_cfg_wdata.
// An accepted transfer is held in an input register and processed from there
// into the result register, from which it leaves on the output channel. One
// transfer per cycle is sustained while the output side accepts; the FIFO
// head is kept in a registered read stage that always follows the read
// pointer, so a pop never waits on the memory. Reset returns the port to
// the cleared mode, status 0x05, receive delay 8 and an empty FIFO. While
// the output side stalls, the result register holds and one more transfer
// waits in the input register before s_axis_tready drops.
// ============================================================================
module usart_receive_status_port #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // value[7:0]
    input  logic [2:0]                       s_axis_tuser,  // func[2:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata,  // read_data[7:0], irq_level[8]
    input  logic                             i_cfg_we,
    input  logic [usart_rsp_pkg::DATA_W-1:0] i_cfg_wdata
);
    import usart_rsp_pkg::*;

    logic              r_in_valid;
    logic [FUNC_W-1:0] r_in_func;
    logic [DATA_W-1:0] r_in_value;
    logic              r_out_valid;
    logic              w_advance;
    logic              w_push;
    logic              w_pop;
    t_fifo_flags       w_flags;
    logic [DATA_W-1:0] w_head;
    logic [DATA_W-1:0] w_read_data;
    logic              w_irq_level;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func  <= s_axis_tuser;
            r_in_value <= s_axis_tdata;
        end
    end

    usart_rsp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (r_in_value),
        .i_pop       (w_pop),
        .o_flags     (w_flags),
        .o_head      (w_head)
    );

    usart_rsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_func      (r_in_func),
        .i_value     (r_in_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_flags     (w_flags),
        .i_head      (w_head),
        .o_push      (w_push),
        .o_pop       (w_pop),
        .o_read_data (w_read_data),
        .o_irq_level (w_irq_level)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, w_irq_level, w_read_data};

endmodule

// File: src/usart_rsp_fifo.sv
// ============================================================================
// usart_rsp_fifo
// Receive FIFO with a registered head read that follows the read pointer.
// ============================================================================
module usart_rsp_fifo #(
    parameter int DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [usart_rsp_pkg::DATA_W-1:0] i_push_data,
    input  logic                            i_pop,
    output usart_rsp_pkg::t_fifo_flags      o_flags,
    output logic [usart_rsp_pkg::DATA_W-1:0] o_head
);
    import usart_rsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_head;
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     n_wp;
    logic [AW-1:0]     n_rp;
    logic [CW-1:0]     n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp    = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            n_count = r_count + 1'b1;
        end
        if (i_pop) begin
            n_rp    = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // The head register always holds the entry at the read pointer, including
    // one written at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
        if (i_push && (r_wp == n_rp)) begin
            r_head <= i_push_data;
        end else begin
            r_head <= r_mem[n_rp];
        end
    end

    assign o_flags.empty  = (r_count == '0);
    assign o_flags.single = (r_count == CW'(1));
    assign o_flags.full   = (r_count == CW'(DEPTH));
    assign o_head         = r_head;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_flags.full))
        else $error("push into a full receive FIFO");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_flags.empty))
        else $error("pop from an empty receive FIFO");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("receive FIFO count beyond depth");

endmodule

// File: src/usart_rsp_core.sv
// ============================================================================
// usart_rsp_core
// Mode sequencer, status flags, pop timer and result register.
// ============================================================================
module usart_rsp_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic [usart_rsp_pkg::FUNC_W-1:0] i_func,
    input  logic [usart_rsp_pkg::DATA_W-1:0] i_value,
    input  logic                             i_cfg_we,
    input  logic [usart_rsp_pkg::DATA_W-1:0] i_cfg_wdata,
    input  usart_rsp_pkg::t_fifo_flags       i_flags,
    input  logic [usart_rsp_pkg::DATA_W-1:0] i_head,
    output logic                             o_push,
    output logic                             o_pop,
    output logic [usart_rsp_pkg::DATA_W-1:0] o_read_data,
    output logic                             o_irq_level
);
    import usart_rsp_pkg::*;

    typedef enum logic [2:0] {
        M_CLEARED = 3'd0,
        M_SYNC    = 3'd1,
        M_ASYNC   = 3'd2,
        M_SYNC1   = 3'd3,
        M_SYNC2   = 3'd4
    } t_mode;

    t_mode             r_mode,   n_mode;
    logic [DATA_W-1:0] r_status, n_status;
    logic              r_rx_en,  n_rx_en;
    logic              r_tx_en,  n_tx_en;
    logic [DATA_W-1:0] r_held,   n_held;
    logic [DATA_W-1:0] r_delay,  n_delay;
    logic              r_irq,    n_irq;
    logic [DATA_W-1:0] r_recv_delay;
    logic [DATA_W-1:0] r_rd,     n_rd;
    logic [DATA_W-1:0] w_arm;
    t_func             w_func;

    assign w_func = t_func'(i_func);
    assign w_arm  = (r_recv_delay == '0) ? DATA_W'(1) : r_recv_delay;

    always_comb begin
        n_mode   = r_mode;
        n_status = r_status;
        n_rx_en  = r_rx_en;
        n_tx_en  = r_tx_en;
        n_held   = r_held;
        n_delay  = r_delay;
        n_irq    = r_irq;
        n_rd     = '0;
        o_push   = 1'b0;
        o_pop    = 1'b0;
        if (i_advance) begin
            case (w_func)
                FN_DATA_WR: begin
                    if (r_status[ST_TXRDY]) begin
                        n_status[ST_TXE] = 1'b0;
                    end
                end
                FN_DATA_RD: begin
                    n_status[ST_RXRDY] = 1'b0;
                    n_irq              = 1'b0;
                    n_rd               = r_held;
                end
                FN_CMD_WR: begin
                    unique case (r_mode)
                        M_SYNC1: n_mode = M_SYNC2;
                        M_SYNC2: n_mode = M_SYNC;
                        M_ASYNC, M_SYNC: begin
                            if (i_value[CMD_IRST]) begin
                                n_mode = M_CLEARED;
                            end else begin
                                if (i_value[CMD_ERR_RST]) begin
                                    n_status = r_status & ~ST_ERRS_MASK;
                                end
                                n_rx_en = i_value[CMD_RXEN];
                                n_tx_en = i_value[CMD_TXEN];
                            end
                        end
                        default: begin
                            if (i_value[1:0] != 2'b00) begin
                                n_mode = M_ASYNC;
                            end else if (i_value[CMD_SYNC_SC]) begin
                                n_mode = M_SYNC2;
                            end else begin
                                n_mode = M_SYNC1;
                            end
                        end
                    endcase
                end
                FN_STAT_RD: begin
                    n_rd = r_status;
                    if (r_tx_en) begin
                        n_status[ST_TXE] = 1'b1;
                    end
                end
                FN_RX_BYTE: begin
                    if (!i_flags.full) begin
                        o_push = 1'b1;
                        if (i_flags.empty) begin
                            n_delay = w_arm;
                        end
                    end
                end
                FN_TICK: begin
                    if (r_delay != '0) begin
                        n_delay = r_delay - 1'b1;
                        if ((r_delay == DATA_W'(1)) && !i_flags.empty) begin
                            o_pop = 1'b1;
                            if (r_rx_en) begin
                                if (!r_status[ST_RXRDY]) begin
                                    n_status[ST_RXRDY] = 1'b1;
                                    n_held             = i_head;
                                    n_irq              = 1'b1;
                                end else begin
                                    n_status[ST_OE] = 1'b1;
                                end
                            end
                            if (!i_flags.single) begin
                                n_delay = w_arm;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_CLEARED;
            r_status     <= STATUS_RST;
            r_rx_en      <= 1'b0;
            r_tx_en      <= 1'b0;
            r_held       <= HELD_RST;
            r_delay      <= '0;
            r_irq        <= 1'b0;
            r_recv_delay <= RECV_DELAY_RST;
        end else begin
            r_mode   <= n_mode;
            r_status <= n_status;
            r_rx_en  <= n_rx_en;
            r_tx_en  <= n_tx_en;
            r_held   <= n_held;
            r_delay  <= n_delay;
            r_irq    <= n_irq;
            if (i_cfg_we) begin
                r_recv_delay <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_rd <= n_rd;
        end
    end

    assign o_read_data = r_rd;
    assign o_irq_level = r_irq;

    a_irq_tracks_rxrdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq == r_status[ST_RXRDY])
        else $error("interrupt level differs from RXRDY");

    a_timer_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_flags.empty |-> (r_delay != '0))
        else $error("bytes queued while the pop timer is idle");

    a_pop_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_advance && (w_func == FN_TICK)))
        else $error("FIFO pop outside a tick transfer");

endmodule

// File: sim/usart_receive_status_port_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// usart_receive_status_port_checker
// Watches both stream channels, predicts each result and compares it.
// ============================================================================
// Every accepted input transfer is applied to a cycle-free model of the
// port: the mode sequencer, the status byte, the receive FIFO with its pop
// timer and the interrupt line. The predicted result is queued, and every
// accepted output transfer is compared field by field with the oldest entry.
// Writes of the receive delay register are tracked from the configuration
// port. The mismatch count and the number of outstanding results are handed
// to the testbench top.
// ============================================================================
module usart_receive_status_port_checker #(
    parameter int FIFO_SLOTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,
    input  logic [2:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [15:0]                      m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [usart_rsp_pkg::DATA_W-1:0] i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import usart_rsp_pkg::*;

    typedef enum logic [2:0] {
        PM_CLEARED   = 3'd0,
        PM_SYNC      = 3'd1,
        PM_ASYNC     = 3'd2,
        PM_SYNC_CHR2 = 3'd3,
        PM_SYNC_CHR1 = 3'd4
    } t_port_mode;

    typedef struct {
        logic [DATA_W-1:0] rd;
        logic              irq;
    } t_port_result;

    t_port_result      expected_replies[$];
    int                mismatches = 0;
    int                replies_seen = 0;

    t_port_mode        mode;
    logic [DATA_W-1:0] status;
    logic              rx_on;
    logic              tx_on;
    logic [DATA_W-1:0] held;
    logic [DATA_W-1:0] fifo_mem [FIFO_SLOTS];
    int                fifo_level;
    int                head;
    int                tail;
    logic [DATA_W-1:0] pop_timer;
    logic              irq_line;
    logic [DATA_W-1:0] rx_delay;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: result %0d, %s: got %02h, expected %02h",
                 $time, replies_seen, what, got, want);
        mismatches++;
    endtask

    task automatic reset_model();
        mode       = PM_CLEARED;
        status     = STATUS_RST;
        rx_on      = 1'b0;
        tx_on      = 1'b0;
        held       = HELD_RST;
        fifo_level = 0;
        head       = 0;
        tail       = 0;
        pop_timer  = '0;
        irq_line   = 1'b0;
        rx_delay   = RECV_DELAY_RST;
    endtask

    // A zero delay setting behaves as a delay of one tick.
    task automatic arm_timer();
        pop_timer = (rx_delay == '0) ? 8'd1 : rx_delay;
    endtask

    task automatic push_line_byte(input logic [7:0] v);
        if (fifo_level < FIFO_SLOTS) begin
            fifo_mem[tail] = v;
            tail = (tail + 1) % FIFO_SLOTS;
            fifo_level++;
            if (fifo_level == 1) arm_timer();
        end
    endtask

    task automatic pop_line_byte();
        logic [7:0] v;
        if (fifo_level == 0) return;
        v = fifo_mem[head];
        head = (head + 1) % FIFO_SLOTS;
        fifo_level--;
        if (rx_on) begin
            if (!status[ST_RXRDY]) begin
                status[ST_RXRDY] = 1'b1;
                held = v;
                irq_line = 1'b1;
            end else begin
                status[ST_OE] = 1'b1;
            end
        end
        if (fifo_level > 0) arm_timer();
    endtask

    task automatic write_command(input logic [7:0] v);
        case (mode)
            PM_SYNC_CHR2: mode = PM_SYNC_CHR1;
            PM_SYNC_CHR1: mode = PM_SYNC;
            PM_ASYNC, PM_SYNC: begin
                if (v[CMD_IRST]) begin
                    mode = PM_CLEARED;
                end else begin
                    if (v[CMD_ERR_RST]) status = status & ~ST_ERRS_MASK;
                    rx_on = v[CMD_RXEN];
                    tx_on = v[CMD_TXEN];
                end
            end
            default: begin
                if (v[1:0] != 2'b00) mode = PM_ASYNC;
                else if (v[CMD_SYNC_SC]) mode = PM_SYNC_CHR1;
                else mode = PM_SYNC_CHR2;
            end
        endcase
    endtask

    task automatic apply_event(input logic [2:0] fn, input logic [7:0] v,
                               output logic [7:0] rd);
        rd = '0;
        case (fn)
            FN_DATA_WR: if (status[ST_TXRDY]) status[ST_TXE] = 1'b0;
            FN_DATA_RD: begin
                status[ST_RXRDY] = 1'b0;
                irq_line = 1'b0;
                rd = held;
            end
            FN_CMD_WR: write_command(v);
            FN_STAT_RD: begin
                rd = status;
                if (tx_on) status[ST_TXE] = 1'b1;
            end
            FN_RX_BYTE: push_line_byte(v);
            FN_TICK: begin
                if (pop_timer != '0) begin
                    pop_timer = pop_timer - 8'd1;
                    if (pop_timer == '0) pop_line_byte();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_reply();
        t_port_result want;
        replies_seen++;
        if (expected_replies.size() == 0) begin
            report_mismatch("result with nothing expected", m_axis_tdata[7:0], 8'h00);
            return;
        end
        want = expected_replies.pop_front();
        if (m_axis_tdata[7:0] !== want.rd) begin
            report_mismatch("read_data", m_axis_tdata[7:0], want.rd);
        end
        if (m_axis_tdata[8] !== want.irq) begin
            report_mismatch("irq_level", {7'b0, m_axis_tdata[8]}, {7'b0, want.irq});
        end
    endtask

    // The output side is handled before the input side: a result leaving at
    // the same edge always belongs to an earlier transfer.
    always @(posedge i_clk) begin
        logic [7:0] rd;
        if (!i_rst_n) begin
            reset_model();
            expected_replies.delete();
        end else begin
            if (i_cfg_we) rx_delay = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) check_reply();
            if (s_axis_tvalid && s_axis_tready) begin
                apply_event(s_axis_tuser, s_axis_tdata, rd);
                expected_replies.push_back('{rd, irq_line});
            end
        end
        o_pending <= expected_replies.size();
    end

endmodule

// File: sim/usart_receive_status_port_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// usart_receive_status_port_tb
// Regression bench for the USART receive and status port.
// ============================================================================
// A directed sequence walks the status and data registers, every path of
// the mode sequencer out of the cleared mode, the unused function codes and
// one timed pop at the reset delay. Random phases then run mode setup,
// enable and event sequences at several receive delays, one of them flooding
// the FIFO past full while the output side holds off for a long stretch. The
// sender idles in bursts and the receiver stalls on a random pattern; the
// checker predicts and compares every result.
// ============================================================================
module usart_receive_status_port_tb;
    import usart_rsp_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
    localparam int         PHASES           = 7;
    localparam logic [7:0] DELAY_PLAN [PHASES] = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd1, 8'd5,
                                                   8'd3};
    localparam int         FLOOD_PHASE      = 4;
    localparam int         FLOOD_BYTES      = 264;
    localparam int         PHASE_ITEMS      = 150;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         SETTLE_CYCLES    = 4;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [7:0]          s_axis_tdata = '0;
    logic [FUNC_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tready = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [DATA_W-1:0]   i_cfg_wdata = '0;
    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [15:0]         m_axis_tdata;

    int                  fail_count;
    int                  pending;
    int                  items_sent = 0;
    int                  settings_used = 0;
    int                  burst_left = 0;
    int                  hold_req = 0;
    int                  hold_ack = 0;
    int                  hold_left = 0;
    int                  pat_pos = 0;
    bit                  gaps_on = 1'b1;
    bit                  stalls_on = 1'b1;
    logic [31:0]         stall_pat = '1;

    usart_receive_status_port u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    usart_receive_status_port_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #10 i_clk = ~i_clk;

    // When stalls are on, the output side stalls on a random pattern; it also
    // holds off completely for a long stretch on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!stalls_on) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (pat_pos == 0) begin
                    stall_pat = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
                end
                m_axis_tready <= stall_pat[pat_pos] | stall_pat[pat_pos + 16];
                pat_pos = (pat_pos + 1) % 16;
            end
        end
    end

    task automatic send(input logic [FUNC_W-1:0] fn, input logic [7:0] v);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_delay(input logic [7:0] d);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_event();
        int         pick;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        v = $urandom_range(0, 255);
        if (pick < 35) send(FN_RX_BYTE, v);
        else if (pick < 65) send(FN_TICK, v);
        else if (pick < 75) send(FN_DATA_RD, v);
        else if (pick < 85) send(FN_STAT_RD, v);
        else if (pick < 90) send(FN_DATA_WR, v);
        else if (pick < 96) begin
            v[CMD_IRST] = 1'b0;
            send(FN_CMD_WR, v);
        end else if (pick < 98) send(FN_CMD_WR, v);
        else send(3'($urandom_range(0, 7)), v);
    endtask

    // Mode setup, then an enabling command, a body of events, and a command with
    // the internal reset bit set, which returns sync or async mode to cleared.
    task automatic run_episode(input int body_len);
        logic [7:0] v;
        v = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0) begin
            if (v[1:0] == 2'b00) v[1:0] = 2'($urandom_range(1, 3));
            send(FN_CMD_WR, v);
        end else begin
            v[1:0] = 2'b00;
            send(FN_CMD_WR, v);
            send(FN_CMD_WR, 8'($urandom_range(0, 255)));
            if (!v[CMD_SYNC_SC]) send(FN_CMD_WR, 8'($urandom_range(0, 255)));
        end
        v = $urandom_range(0, 255);
        v[CMD_IRST] = 1'b0;
        if ($urandom_range(0, 6) != 0) v[CMD_RXEN] = 1'b1;
        send(FN_CMD_WR, v);
        repeat (body_len) send_random_event();
        v = $urandom_range(0, 255);
        v[CMD_IRST] = 1'b1;
        send(FN_CMD_WR, v);
    endtask

    task automatic run_phase(input int p, input logic [7:0] d);
        int phase_base;
        set_delay(d);
        gaps_on   = (p % 3) != 1;
        stalls_on = (p % 3) != 2;
        phase_base = items_sent;
        if (p == FLOOD_PHASE) begin
            hold_req++;
            repeat (FLOOD_BYTES) send(FN_RX_BYTE, 8'($urandom_range(0, 255)));
        end
        while (items_sent - phase_base < PHASE_ITEMS) run_episode($urandom_range(10, 40));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(FN_STAT_RD, 8'h00);
        send(FN_DATA_RD, 8'hff);
        send(FN_DATA_WR, 8'hff);
        send(FN_STAT_RD, 8'h00);
        send(FN_SPARE_6, 8'hff);
        send(FN_SPARE_7, 8'h00);
        send(FN_TICK, 8'hff);
        send(FN_CMD_WR, 8'h80);
        send(FN_CMD_WR, 8'h00);
        send(FN_CMD_WR, 8'h40);
        send(FN_CMD_WR, 8'h00);
        send(FN_CMD_WR, 8'hff);
        send(FN_CMD_WR, 8'h7f);
        send(FN_CMD_WR, 8'h40);
        send(FN_CMD_WR, 8'hff);
        send(FN_CMD_WR, 8'h15);
        send(FN_STAT_RD, 8'h00);
        send(FN_RX_BYTE, 8'h00);
        repeat (RECV_DELAY_RST) send(FN_TICK, 8'h00);
        send(FN_STAT_RD, 8'hff);
        send(FN_DATA_RD, 8'h00);

        for (int p = 0; p < PHASES; p++) run_phase(p, DELAY_PLAN[p]);
        drain();

        $display("Ran %0d input transfers over %0d receive delay settings plus the reset one.",
                 items_sent, settings_used);
        $display("Stimulus included a FIFO overflow, a long output hold-off and unused codes.");
        if (fail_count == 0) begin
            $display("usart_receive_status_port regression: pass");
        end else begin
            $display("usart_receive_status_port regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("usart_receive_status_port regression: fail");
        $finish;
    end

endmodule
